>>> rtl/cca_pkg.sv
package cca_pkg;

    // channel address: plane<<13 | quadrant<<11 | row<<8 | strip
    localparam int ADDR_BITS = 15;
    localparam int CHAN_DEPTH = 1 << ADDR_BITS;
    localparam int MAX_ROW = 4;

    // touched map: one bit per channel, packed in words
    localparam int TBIT_BITS = 5;
    localparam int TWORD_W = 1 << TBIT_BITS;
    localparam int TWORD_BITS = ADDR_BITS - TBIT_BITS;
    localparam int TWORD_DEPTH = 1 << TWORD_BITS;

    // scan visits every word once plus the start word again
    localparam int SCNT_BITS = TWORD_BITS + 1;
    localparam logic [SCNT_BITS-1:0] SCAN_LAST = SCNT_BITS'(TWORD_DEPTH);

    localparam int SUM_W = 20;
    localparam int CHG_W = 16;
    localparam int ID_W = 16;
    localparam int ORI_W = 2;
    localparam int ADC_W = 10;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [ADC_W-1:0] ADC_MAX = '1;

    // register map
    localparam logic REG_ADC_THRESHOLD = 1'b0;

    // request function codes
    localparam logic FUNC_ACCUM = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DRAIN,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CHG_W-1:0] largest;
        logic [ID_W-1:0]  dom_id;
        logic [ORI_W-1:0] ori;
        logic             center;
    } t_chan_rec;

    typedef enum logic [2:0] {
        TOP_NONE,
        TOP_READ,
        TOP_ZERO,
        TOP_SET,
        TOP_CLR
    } t_touch_op;

    typedef struct packed {
        t_touch_op             op;
        logic [TWORD_BITS-1:0] word;
        logic [TBIT_BITS-1:0]  bit_idx;
    } t_touch_cmd;

    typedef struct packed {
        logic [TWORD_W-1:0]   word;
        logic                 hit;
        logic [TBIT_BITS-1:0] first;
    } t_touch_stat;

endpackage

>>> rtl/cca_touch_map.sv
module cca_touch_map (
    input  logic                            i_clk,
    input  cca_pkg::t_touch_cmd             i_cmd,
    input  logic [cca_pkg::TBIT_BITS-1:0]   i_scan_lo,
    output cca_pkg::t_touch_stat            o_stat
);

    logic [cca_pkg::TWORD_W-1:0] r_mem [cca_pkg::TWORD_DEPTH];
    logic [cca_pkg::TWORD_W-1:0] r_q;
    logic [cca_pkg::TWORD_W-1:0] wr_data;
    logic                        wr_en;
    logic [cca_pkg::TWORD_W-1:0] onehot;
    logic [cca_pkg::TWORD_W-1:0] masked;
    logic                        hit;
    logic [cca_pkg::TBIT_BITS-1:0] first;

    // set and clear modify the word read in the previous step
    assign onehot = cca_pkg::TWORD_W'(1) << i_cmd.bit_idx;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = '0;
        unique case (i_cmd.op)
            cca_pkg::TOP_ZERO: begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            cca_pkg::TOP_SET: begin
                wr_en   = 1'b1;
                wr_data = r_q | onehot;
            end
            cca_pkg::TOP_CLR: begin
                wr_en   = 1'b1;
                wr_data = r_q & ~onehot;
            end
            cca_pkg::TOP_NONE, cca_pkg::TOP_READ: begin
                wr_en   = 1'b0;
            end
            default: begin
                wr_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cca_pkg::TOP_READ) begin
            r_q <= r_mem[i_cmd.word];
        end
        if (wr_en) begin
            r_mem[i_cmd.word] <= wr_data;
        end
    end

    // lowest touched bit at or above the scan start
    assign masked = r_q & ({cca_pkg::TWORD_W{1'b1}} << i_scan_lo);

    always_comb begin
        hit   = |masked;
        first = '0;
        for (int i = cca_pkg::TWORD_W - 1; i >= 0; i--) begin
            if (masked[i]) begin
                first = cca_pkg::TBIT_BITS'(i);
            end
        end
    end

    assign o_stat = '{word: r_q, hit: hit, first: first};

endmodule

>>> rtl/channel_charge_accumulator_core.sv
// Channel charge accumulator with zero suppression.
// Input channel (i_valid/o_ready) takes one request per accept. Func 0 adds a
// charge to the addressed channel: the record is read from the channel
// memory and written back in the next cycle, and ready returns right
// after. Out-of-range addresses are dropped in the accept cycle. Func 1
// drains the next touched channel in circular address order: the touched
// map is scanned one 32-channel word at a time, up to 1025 words, and an
// empty store yields a result with o_found low.
// A suppressed channel is cleared and yields no result.
// Result channel (o_valid/i_ready) is an output register; a new request is
// taken while a result waits. A drain that must emit holds, with o_ready
// low, until the output register is free, so a stalled receiver blocks the
// input once a second result is ready.
// After reset the touched map is cleared, one word a cycle,
// with o_ready low; configuration writes are taken at any time.
// APB register 0 (address 0): adc_threshold, 16 bits, reset 0.
module channel_charge_accumulator_core #(
    parameter int PLANES    = 4,
    parameter int QUADRANTS = 4,
    parameter int STRIPS    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [1:0]  i_plane,
    input  logic [1:0]  i_quadrant,
    input  logic [2:0]  i_row,
    input  logic [7:0]  i_strip,
    input  logic [15:0] i_charge,
    input  logic [15:0] i_truth_id,
    input  logic [1:0]  i_orientation,
    input  logic        i_is_center,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [1:0]  o_out_plane,
    output logic [1:0]  o_out_quadrant,
    output logic [2:0]  o_out_row,
    output logic [7:0]  o_out_strip,
    output logic [9:0]  o_out_adc,
    output logic [15:0] o_out_truth_id,
    output logic [1:0]  o_out_orientation
);

    cca_pkg::t_state r_state, n_state;

    logic [cca_pkg::TWORD_BITS-1:0] r_clr_cnt;
    logic [cca_pkg::ADDR_BITS-1:0]  r_ptr;
    logic [15:0]                    r_thr;
    logic [cca_pkg::TWORD_BITS-1:0] r_scan_word;
    logic [cca_pkg::SCNT_BITS-1:0]  r_scan_cnt;
    logic                           r_out_valid;

    // request fields held for write-back
    logic [cca_pkg::ADDR_BITS-1:0]  r_addr;
    logic [cca_pkg::CHG_W-1:0]      r_chg;
    logic [cca_pkg::ID_W-1:0]       r_tid;
    logic [cca_pkg::ORI_W-1:0]      r_ori;
    logic                           r_ctr;

    // result register
    logic        r_found;
    logic [cca_pkg::ADDR_BITS-1:0] r_out_addr;
    logic [cca_pkg::ADC_W-1:0]     r_adc;
    logic [cca_pkg::ID_W-1:0]      r_out_tid;
    logic [cca_pkg::ORI_W-1:0]     r_out_ori;

    // channel memory
    cca_pkg::t_chan_rec r_data_mem [cca_pkg::CHAN_DEPTH];
    cca_pkg::t_chan_rec r_dq;
    logic                          d_rd_en;
    logic [cca_pkg::ADDR_BITS-1:0] d_rd_addr;
    logic                          d_wr_en;
    cca_pkg::t_chan_rec            d_wr_data;

    cca_pkg::t_touch_cmd  t_cmd;
    cca_pkg::t_touch_stat t_stat;
    logic [cca_pkg::TBIT_BITS-1:0] scan_lo;

    logic                          in_accept;
    logic                          in_range;
    logic                          acc_go;
    logic                          drain_go;
    logic [cca_pkg::ADDR_BITS-1:0] in_addr;
    logic [cca_pkg::ADDR_BITS-1:0] hit_addr;
    logic                          out_free;
    logic                          out_load;
    logic                          cfg_wr;

    cca_pkg::t_chan_rec            base;
    logic [cca_pkg::SUM_W:0]       sum_wide;
    logic                          below;
    logic                          emit;
    logic [cca_pkg::SUM_W-1:0]     adc_val;
    logic [cca_pkg::SUM_W-5:0]     adc_full;
    logic [cca_pkg::ADC_W-1:0]     adc;

    // request decode
    assign o_ready   = (r_state == cca_pkg::S_IDLE);
    assign in_accept = i_valid && o_ready;
    assign in_range  = (32'(i_plane) < PLANES) && (32'(i_quadrant) < QUADRANTS) &&
                       (32'(i_row) <= cca_pkg::MAX_ROW) && (32'(i_strip) < STRIPS);
    assign acc_go    = in_accept && (i_func == cca_pkg::FUNC_ACCUM) && in_range;
    assign drain_go  = in_accept && (i_func == cca_pkg::FUNC_DRAIN);
    assign in_addr   = {i_plane, i_quadrant, i_row, i_strip};
    assign hit_addr  = {r_scan_word, t_stat.first};
    assign out_free  = !r_out_valid || i_ready;
    assign scan_lo   = (r_scan_cnt == '0) ? r_ptr[cca_pkg::TBIT_BITS-1:0] : '0;

    // config port
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == cca_pkg::REG_ADC_THRESHOLD);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cca_pkg::REG_ADC_THRESHOLD) ? {16'b0, r_thr} : '0;

    // accumulate merge
    always_comb begin
        base     = t_stat.word[r_addr[cca_pkg::TBIT_BITS-1:0]] ? r_dq : '0;
        sum_wide = {1'b0, base.sum} + (cca_pkg::SUM_W + 1)'(r_chg);
        d_wr_data.sum    = sum_wide[cca_pkg::SUM_W] ? cca_pkg::SUM_MAX
                                                    : sum_wide[cca_pkg::SUM_W-1:0];
        d_wr_data.ori    = r_ori;
        d_wr_data.center = base.center | r_ctr;
        if (r_chg > base.largest) begin
            d_wr_data.largest = r_chg;
            d_wr_data.dom_id  = r_tid;
        end else begin
            d_wr_data.largest = base.largest;
            d_wr_data.dom_id  = base.dom_id;
        end
    end

    // drain threshold, floor and ADC saturation
    always_comb begin
        below    = r_dq.sum < cca_pkg::SUM_W'(r_thr);
        emit     = !below || r_dq.center;
        adc_val  = below ? cca_pkg::SUM_W'(r_thr) : r_dq.sum;
        adc_full = adc_val[cca_pkg::SUM_W-1:4];
        adc      = (adc_full > (cca_pkg::SUM_W-4)'(cca_pkg::ADC_MAX)) ? cca_pkg::ADC_MAX
                                                                     : adc_full[9:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cca_pkg::S_CLEAR: begin
                if (r_clr_cnt == '1) n_state = cca_pkg::S_IDLE;
            end
            cca_pkg::S_IDLE: begin
                if (acc_go) n_state = cca_pkg::S_ACC_WR;
                else if (drain_go) n_state = cca_pkg::S_SCAN_RD;
            end
            cca_pkg::S_ACC_WR: n_state = cca_pkg::S_IDLE;
            cca_pkg::S_SCAN_RD: n_state = cca_pkg::S_SCAN_CHK;
            cca_pkg::S_SCAN_CHK: begin
                if (t_stat.hit) n_state = cca_pkg::S_DRAIN;
                else if (r_scan_cnt == cca_pkg::SCAN_LAST) n_state = cca_pkg::S_EMPTY;
                else n_state = cca_pkg::S_SCAN_RD;
            end
            cca_pkg::S_DRAIN: begin
                if (!emit || out_free) n_state = cca_pkg::S_IDLE;
            end
            cca_pkg::S_EMPTY: begin
                if (out_free) n_state = cca_pkg::S_IDLE;
            end
            default: n_state = cca_pkg::S_IDLE;
        endcase
    end

    // state outputs: memory commands and result load
    always_comb begin
        t_cmd     = '{op: cca_pkg::TOP_NONE, word: '0, bit_idx: '0};
        d_rd_en   = 1'b0;
        d_rd_addr = in_addr;
        d_wr_en   = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            cca_pkg::S_CLEAR: begin
                t_cmd = '{op: cca_pkg::TOP_ZERO, word: r_clr_cnt, bit_idx: '0};
            end
            cca_pkg::S_IDLE: begin
                if (acc_go) begin
                    t_cmd = '{op: cca_pkg::TOP_READ,
                              word: in_addr[cca_pkg::ADDR_BITS-1:cca_pkg::TBIT_BITS],
                              bit_idx: '0};
                    d_rd_en = 1'b1;
                end
            end
            cca_pkg::S_ACC_WR: begin
                t_cmd = '{op: cca_pkg::TOP_SET,
                          word: r_addr[cca_pkg::ADDR_BITS-1:cca_pkg::TBIT_BITS],
                          bit_idx: r_addr[cca_pkg::TBIT_BITS-1:0]};
                d_wr_en = 1'b1;
            end
            cca_pkg::S_SCAN_RD: begin
                t_cmd = '{op: cca_pkg::TOP_READ, word: r_scan_word, bit_idx: '0};
            end
            cca_pkg::S_SCAN_CHK: begin
                if (t_stat.hit) begin
                    t_cmd = '{op: cca_pkg::TOP_CLR, word: r_scan_word,
                              bit_idx: t_stat.first};
                    d_rd_en   = 1'b1;
                    d_rd_addr = hit_addr;
                end
            end
            cca_pkg::S_DRAIN: begin
                out_load = emit && out_free;
            end
            cca_pkg::S_EMPTY: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    cca_touch_map u_touch (
        .i_clk     (i_clk),
        .i_cmd     (t_cmd),
        .i_scan_lo (scan_lo),
        .o_stat    (t_stat)
    );

    // channel memory, registered read
    always_ff @(posedge i_clk) begin
        if (d_rd_en) begin
            r_dq <= r_data_mem[d_rd_addr];
        end
        if (d_wr_en) begin
            r_data_mem[r_addr] <= d_wr_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cca_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_ptr       <= '0;
            r_thr       <= '0;
            r_scan_word <= '0;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cca_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (cfg_wr) begin
                r_thr <= pwdata[15:0];
            end
            if (drain_go) begin
                r_scan_word <= r_ptr[cca_pkg::ADDR_BITS-1:cca_pkg::TBIT_BITS];
                r_scan_cnt  <= '0;
            end else if (r_state == cca_pkg::S_SCAN_CHK) begin
                if (t_stat.hit) begin
                    r_ptr <= hit_addr + 1'b1;
                end else if (r_scan_cnt != cca_pkg::SCAN_LAST) begin
                    r_scan_word <= r_scan_word + 1'b1;
                    r_scan_cnt  <= r_scan_cnt + 1'b1;
                end
            end
            if (out_load && (r_state == cca_pkg::S_EMPTY)) begin
                r_ptr <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc_go) begin
            r_addr <= in_addr;
            r_chg  <= i_charge;
            r_tid  <= i_truth_id;
            r_ori  <= i_orientation;
            r_ctr  <= i_is_center;
        end else if ((r_state == cca_pkg::S_SCAN_CHK) && t_stat.hit) begin
            r_addr <= hit_addr;
        end
        if (out_load) begin
            if (r_state == cca_pkg::S_EMPTY) begin
                r_found    <= 1'b0;
                r_out_addr <= '0;
                r_adc      <= '0;
                r_out_tid  <= '0;
                r_out_ori  <= '0;
            end else begin
                r_found    <= 1'b1;
                r_out_addr <= r_addr;
                r_adc      <= adc;
                r_out_tid  <= r_dq.dom_id;
                r_out_ori  <= r_dq.ori;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_found           = r_found;
    assign o_out_plane       = r_out_addr[14:13];
    assign o_out_quadrant    = r_out_addr[12:11];
    assign o_out_row         = r_out_addr[10:8];
    assign o_out_strip       = r_out_addr[7:0];
    assign o_out_adc         = r_adc;
    assign o_out_truth_id    = r_out_tid;
    assign o_out_orientation = r_out_ori;

`ifndef NO_ASSERTIONS
    // no result can appear while the touched map is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cca_pkg::S_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing pass");

    // an accepted in-range accumulate is written back in the next cycle
    a_acc_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_go |=> (r_state == cca_pkg::S_ACC_WR))
        else $error("accumulate write-back missed");

    // the result register is only loaded when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_ready))
        else $error("result overwritten before taken");

    // the scan never runs past one full lap plus the start word
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cca_pkg::S_SCAN_CHK) |-> (r_scan_cnt <= cca_pkg::SCAN_LAST))
        else $error("drain scan ran past one lap");
`endif

endmodule

>>> sim/tb_channel_charge_accumulator_core.sv
module tb_channel_charge_accumulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cca_pkg::*;

    localparam int CHAN_PLANES    = 4;
    localparam int CHAN_QUADRANTS = 4;
    localparam int CHAN_STRIPS    = 256;

    localparam logic [2:0] THR_ADDR = 3'(4 * REG_ADC_THRESHOLD);

    // longest drain is a full lap of the touched map plus the start word
    localparam int SETTLE_CYCLES = 2 * TWORD_DEPTH + 64;
    localparam int TIMEOUT_CYCLES = 20_000_000;
    localparam int RAND_ITEMS = 1500;
    localparam int HOLD_CYCLES = 5000;
    localparam int MAX_REPORTS = 10;

    // event flavors for the random part
    localparam int EV_PILEUP = 0;   // one channel hit repeatedly so its sum can saturate
    localparam int EV_SPREAD = 1;   // hits anywhere in the address space
    localparam int EV_OPEN   = 2;   // drained only partly, leftovers carry over
    localparam int EV_PLAIN  = 3;

    typedef struct packed {
        logic             func;
        logic [1:0]       plane;
        logic [1:0]       quadrant;
        logic [2:0]       row;
        logic [7:0]       strip;
        logic [CHG_W-1:0] charge;
        logic [ID_W-1:0]  truth_id;
        logic [ORI_W-1:0] orientation;
        logic             is_center;
    } t_chan_req;

    typedef struct packed {
        logic             found;
        logic [1:0]       plane;
        logic [1:0]       quadrant;
        logic [2:0]       row;
        logic [7:0]       strip;
        logic [ADC_W-1:0] adc;
        logic [ID_W-1:0]  truth_id;
        logic [ORI_W-1:0] orientation;
    } t_chan_hit;

    typedef enum logic {
        STEP_REQ,
        STEP_THR
    } t_step_kind;

    typedef struct {
        t_step_kind  kind;
        t_chan_req   req;
        bit          typed;
        t_chan_hit   want;
        logic [15:0] thr;
    } t_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [1:0]  i_plane;
    logic [1:0]  i_quadrant;
    logic [2:0]  i_row;
    logic [7:0]  i_strip;
    logic [15:0] i_charge;
    logic [15:0] i_truth_id;
    logic [1:0]  i_orientation;
    logic        i_is_center;
    logic        o_valid;
    logic        i_ready;
    logic        o_found;
    logic [1:0]  o_out_plane;
    logic [1:0]  o_out_quadrant;
    logic [2:0]  o_out_row;
    logic [7:0]  o_out_strip;
    logic [9:0]  o_out_adc;
    logic [15:0] o_out_truth_id;
    logic [1:0]  o_out_orientation;

    channel_charge_accumulator_core #(
        .PLANES    (CHAN_PLANES),
        .QUADRANTS (CHAN_QUADRANTS),
        .STRIPS    (CHAN_STRIPS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_plane           (i_plane),
        .i_quadrant        (i_quadrant),
        .i_row             (i_row),
        .i_strip           (i_strip),
        .i_charge          (i_charge),
        .i_truth_id        (i_truth_id),
        .i_orientation     (i_orientation),
        .i_is_center       (i_is_center),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_found           (o_found),
        .o_out_plane       (o_out_plane),
        .o_out_quadrant    (o_out_quadrant),
        .o_out_row         (o_out_row),
        .o_out_strip       (o_out_strip),
        .o_out_adc         (o_out_adc),
        .o_out_truth_id    (o_out_truth_id),
        .o_out_orientation (o_out_orientation)
    );

    // shadow of the channel store
    bit               ch_touched [CHAN_DEPTH];
    logic [SUM_W-1:0] ch_sum     [CHAN_DEPTH];
    logic [CHG_W-1:0] ch_big     [CHAN_DEPTH];
    logic [ID_W-1:0]  ch_dom     [CHAN_DEPTH];
    logic [ORI_W-1:0] ch_ori     [CHAN_DEPTH];
    bit               ch_ctr     [CHAN_DEPTH];
    int               live_count = 0;
    logic [ADDR_BITS-1:0] scan_ptr = '0;
    logic [15:0]      cfg_thr = '0;

    t_chan_hit pending_hits [$];

    int err_count    = 0;
    int n_requests   = 0;
    int taken_items  = 0;
    int n_checked    = 0;
    int n_emitted    = 0;
    int n_empty      = 0;
    int n_suppressed = 0;
    int n_sum_sat    = 0;
    int n_thr_writes = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t ERROR: %s", $realtime, msg);
        end
    endfunction

    // apply one request to the shadow store; returns 1 when it yields a result
    function automatic bit predict_request(input t_chan_req r, output t_chan_hit res);
        logic [ADDR_BITS-1:0] a;
        logic [SUM_W:0]       s;
        logic [SUM_W-1:0]     v;
        res = '0;
        if (r.func == FUNC_ACCUM) begin
            if (r.plane >= CHAN_PLANES || r.quadrant >= CHAN_QUADRANTS ||
                r.row > MAX_ROW || r.strip >= CHAN_STRIPS) begin
                return 1'b0;
            end
            a = {r.plane, r.quadrant, r.row, r.strip};
            if (!ch_touched[a]) begin
                ch_touched[a] = 1'b1;
                ch_sum[a] = '0;
                ch_big[a] = '0;
                ch_dom[a] = '0;
                ch_ctr[a] = 1'b0;
                live_count++;
            end
            ch_ori[a] = r.orientation;
            s = {1'b0, ch_sum[a]} + (SUM_W + 1)'(r.charge);
            if (s > {1'b0, SUM_MAX}) begin
                s = {1'b0, SUM_MAX};
                n_sum_sat++;
            end
            ch_sum[a] = s[SUM_W-1:0];
            if (r.is_center) ch_ctr[a] = 1'b1;
            // only a strictly larger part takes over the id
            if (r.charge > ch_big[a]) begin
                ch_big[a] = r.charge;
                ch_dom[a] = r.truth_id;
            end
            return 1'b0;
        end
        // drain with nothing stored: found low, pointer back to zero
        if (live_count == 0) begin
            scan_ptr = '0;
            n_empty++;
            return 1'b1;
        end
        a = scan_ptr;
        while (!ch_touched[a]) a = a + 1'b1;
        ch_touched[a] = 1'b0;
        live_count--;
        scan_ptr = a + 1'b1;
        v = ch_sum[a];
        if (v < SUM_W'(cfg_thr)) begin
            if (!ch_ctr[a]) begin
                n_suppressed++;
                return 1'b0;
            end
            v = SUM_W'(cfg_thr);
        end
        res.found = 1'b1;
        {res.plane, res.quadrant, res.row, res.strip} = a;
        if ((v >> 4) > SUM_W'(ADC_MAX)) res.adc = ADC_MAX;
        else res.adc = v[ADC_W+3:4];
        res.truth_id = ch_dom[a];
        res.orientation = ch_ori[a];
        n_emitted++;
        return 1'b1;
    endfunction

    function automatic t_chan_req noise_req();
        t_chan_req r;
        r.func        = 1'($urandom);
        r.plane       = 2'($urandom);
        r.quadrant    = 2'($urandom);
        r.row         = 3'($urandom);
        r.strip       = 8'($urandom);
        r.charge      = 16'($urandom);
        r.truth_id    = 16'($urandom);
        r.orientation = 2'($urandom);
        r.is_center   = 1'($urandom);
        return r;
    endfunction

    function automatic t_chan_req drain_req();
        t_chan_req r;
        r = noise_req();
        r.func = FUNC_DRAIN;
        return r;
    endfunction

    // valid accumulate, charges biased toward the threshold region
    function automatic t_chan_req rand_accum();
        t_chan_req r;
        r = noise_req();
        r.func = FUNC_ACCUM;
        r.row = 3'($urandom_range(0, MAX_ROW));
        case ($urandom_range(0, 7))
            0: r.charge = 16'hFFFF;
            1: r.charge = 16'h0000;
            2, 3: r.charge = 16'($urandom);
            default: r.charge = 16'($urandom_range(0, 16'h0400));
        endcase
        r.is_center = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    function automatic t_chan_req acc_req(input logic [1:0] pl, input logic [1:0] qd,
                                          input logic [2:0] rw, input logic [7:0] st,
                                          input logic [15:0] chg, input logic [15:0] tid,
                                          input logic [1:0] ori, input logic ctr);
        return {FUNC_ACCUM, pl, qd, rw, st, chg, tid, ori, ctr};
    endfunction

    function automatic t_chan_hit hit_of(input logic [1:0] pl, input logic [1:0] qd,
                                         input logic [2:0] rw, input logic [7:0] st,
                                         input logic [9:0] adc, input logic [15:0] tid,
                                         input logic [1:0] ori);
        return {1'b1, pl, qd, rw, st, adc, tid, ori};
    endfunction

    function automatic t_step req_step(input t_chan_req r, input bit typed = 1'b0,
                                       input t_chan_hit want = '0);
        t_step s;
        s.kind = STEP_REQ;
        s.req = r;
        s.typed = typed;
        s.want = want;
        s.thr = '0;
        return s;
    endfunction

    function automatic t_step thr_step(input logic [15:0] thr_value);
        t_step s;
        s = req_step('0);
        s.kind = STEP_THR;
        s.thr = thr_value;
        return s;
    endfunction

    // offer one request and hold it until taken
    task automatic push_request(input t_chan_req r, input bit typed = 1'b0,
                                input t_chan_hit want = '0);
        t_chan_hit calc;
        bit made;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= r.func;
        i_plane       <= r.plane;
        i_quadrant    <= r.quadrant;
        i_row         <= r.row;
        i_strip       <= r.strip;
        i_charge      <= r.charge;
        i_truth_id    <= r.truth_id;
        i_orientation <= r.orientation;
        i_is_center   <= r.is_center;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_requests++;
        if (r.func == FUNC_DRAIN || r.row <= MAX_ROW) taken_items++;
        made = predict_request(r, calc);
        if (made || typed) pending_hits.push_back(typed ? want : calc);
    endtask

    // stop offering, let every result out, then cover a suppressed drain in flight
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the threshold, then read it back
    task automatic write_threshold(input logic [15:0] thr_value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        pwdata  <= 32'(thr_value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_thr = thr_value;
        n_thr_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[15:0] !== thr_value) begin
            flag_error($sformatf("threshold read back %h, wrote %h", prdata[15:0], thr_value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one event: a burst of contributions, then drains until the store is empty (zero to three drains for EV_OPEN)
    task automatic run_event(input int min_hits, input bit pressure);
        int n_hits;
        int kind;
        int k;
        logic [1:0] pl;
        logic [1:0] qd;
        logic [7:0] sbase;
        t_chan_req r;
        logic [ADDR_BITS-1:0] used [$];
        kind = pressure ? EV_PLAIN : $urandom_range(0, 19);
        pl = 2'($urandom);
        qd = 2'($urandom);
        sbase = 8'($urandom);
        n_hits = $urandom_range(min_hits, min_hits + 13);
        if (kind == EV_PILEUP) n_hits = $urandom_range(20, 24);
        for (k = 0; k < n_hits; k++) begin
            r = rand_accum();
            if (kind != EV_SPREAD) begin
                r.plane = pl;
                r.quadrant = qd;
                r.strip = sbase + 8'($urandom_range(0, 15));
            end
            if (kind == EV_PILEUP) begin
                if (k > 0) {r.plane, r.quadrant, r.row, r.strip} = used[0];
                if ($urandom_range(0, 3) != 0) r.charge = 16'hFFFF;
            end else if (used.size() != 0 && $urandom_range(0, 2) == 0) begin
                {r.plane, r.quadrant, r.row, r.strip} = used[$urandom_range(0, used.size() - 1)];
            end
            used.push_back({r.plane, r.quadrant, r.row, r.strip});
            if (!pressure && $urandom_range(0, 14) == 0) push_request(noise_req());
            push_request(r);
        end
        if (kind == EV_OPEN) begin
            repeat ($urandom_range(0, 3)) push_request(drain_req());
        end else begin
            while (live_count != 0) push_request(drain_req());
            push_request(drain_req());
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random back-pressure, long hold on request, checking
    initial begin : result_side
        int hold_left;
        t_chan_hit got;
        t_chan_hit want;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = {o_found, o_out_plane, o_out_quadrant, o_out_row, o_out_strip,
                       o_out_adc, o_out_truth_id, o_out_orientation};
                if (pending_hits.size() == 0) begin
                    flag_error($sformatf("unexpected result %h", got));
                end else begin
                    want = pending_hits.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        flag_error($sformatf({"result mismatch: found %0d/%0d plane %0d/%0d ",
                            "quad %0d/%0d row %0d/%0d strip %0d/%0d adc %0d/%0d ",
                            "id %h/%h ori %0d/%0d (exp/got)"},
                            want.found, got.found, want.plane, got.plane,
                            want.quadrant, got.quadrant, want.row, got.row,
                            want.strip, got.strip, want.adc, got.adc,
                            want.truth_id, got.truth_id, want.orientation, got.orientation));
                    end
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) hold_left--;
            i_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // request side
    initial begin : request_side
        t_step steps [$];
        int goal;
        logic [15:0] thr_plan [6];

        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_valid       <= 1'b0;
        i_func        <= FUNC_ACCUM;
        i_plane       <= '0;
        i_quadrant    <= '0;
        i_row         <= '0;
        i_strip       <= '0;
        i_charge      <= '0;
        i_truth_id    <= '0;
        i_orientation <= '0;
        i_is_center   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, ties, first touch at zero, range drops,
        // suppression, center floor, ADC clip at both threshold extremes
        steps.push_back(req_step(drain_req(), 1'b1, '0));
        steps.push_back(thr_step(16'h0100));
        steps.push_back(req_step(acc_req(0, 0, 0, 8'h00, 16'hFFFF, 16'hFFFF, 2'd3, 1'b0)));
        steps.push_back(req_step(acc_req(0, 0, 0, 8'h00, 16'hFFFF, 16'h1234, 2'd1, 1'b0)));
        steps.push_back(req_step(acc_req(3, 3, 4, 8'hFF, 16'h0000, 16'hAAAA, 2'd2, 1'b1)));
        steps.push_back(req_step(acc_req(1, 0, 5, 8'h00, 16'h0100, 16'h0042, 2'd0, 1'b1)));
        steps.push_back(req_step(acc_req(2, 2, 7, 8'hFF, 16'hFFFF, 16'h0043, 2'd1, 1'b0)));
        steps.push_back(req_step(acc_req(1, 2, 2, 8'h80, 16'h00FF, 16'h0007, 2'd0, 1'b0)));
        steps.push_back(req_step(acc_req(0, 0, 2, 8'h03, 16'h0000, 16'h5555, 2'd1, 1'b0)));
        steps.push_back(req_step(acc_req(0, 0, 2, 8'h03, 16'h0200, 16'h0009, 2'd0, 1'b0)));
        steps.push_back(req_step(drain_req(), 1'b1,
                                 hit_of(0, 0, 0, 8'h00, ADC_MAX, 16'hFFFF, 2'd1)));
        steps.push_back(req_step(drain_req()));
        steps.push_back(req_step(drain_req()));
        steps.push_back(req_step(drain_req(), 1'b1,
                                 hit_of(3, 3, 4, 8'hFF, 10'd16, 16'h0000, 2'd2)));
        steps.push_back(req_step(drain_req(), 1'b1, '0));
        steps.push_back(thr_step(16'hFFFF));
        steps.push_back(req_step(acc_req(0, 1, 1, 8'h20, 16'hFFFE, 16'h0003, 2'd2, 1'b0)));
        steps.push_back(req_step(acc_req(2, 1, 3, 8'h10, 16'hFFFF, 16'h0001, 2'd3, 1'b0)));
        steps.push_back(req_step(acc_req(2, 1, 3, 8'h11, 16'h8000, 16'h0002, 2'd0, 1'b1)));
        steps.push_back(req_step(drain_req()));
        steps.push_back(req_step(drain_req(), 1'b1,
                                 hit_of(2, 1, 3, 8'h10, ADC_MAX, 16'h0001, 2'd3)));
        steps.push_back(req_step(drain_req(), 1'b1,
                                 hit_of(2, 1, 3, 8'h11, ADC_MAX, 16'h0002, 2'd0)));
        steps.push_back(req_step(drain_req(), 1'b1, '0));

        foreach (steps[k]) begin
            if (steps[k].kind == STEP_THR) begin
                wait_quiet();
                write_threshold(steps[k].thr);
            end else begin
                push_request(steps[k].req, steps[k].typed, steps[k].want);
            end
        end

        // random events in three phases, threshold written before each half of each phase
        thr_plan[0] = 16'($urandom_range(16'h0010, 16'h0800));
        thr_plan[1] = 16'hFFFF;
        thr_plan[2] = 16'($urandom);
        thr_plan[3] = 16'h0000;
        thr_plan[4] = 16'($urandom_range(16'h0040, 16'h0400));
        thr_plan[5] = 16'h0001;
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 14 : (p == 1) ? 70 : 0;
            recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 14 : 0;
            for (int h = 0; h < 2; h++) begin
                wait_quiet();
                write_threshold(thr_plan[2 * p + h]);
                // receiver stalls long while drains keep coming
                if (p == 2 && h == 0) begin
                    hold_req = HOLD_CYCLES;
                    run_event(12, 1'b1);
                end
                goal = taken_items + RAND_ITEMS / 6;
                while (taken_items < goal) run_event(1, 1'b0);
            end
        end

        wait_quiet();
        $display("Covered %0d requests, %0d results checked (%0d channels out, %0d empty drains).",
                 n_requests, n_checked, n_emitted, n_empty);
        $display("%0d channels zero-suppressed, %0d saturating sums, %0d threshold writes.",
                 n_suppressed, n_sum_sat, n_thr_writes);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/cca_pkg.sv
rtl/cca_touch_map.sv
rtl/channel_charge_accumulator_core.sv
sim/tb_channel_charge_accumulator_core.sv
